// ===== hdl/rcokt_pkg.sv =====
// Shared constants, codes and types for the reference-counted slot table.
// Used by the table top level and the slot scanner; depends on nothing else.
package rcokt_pkg;

   localparam int NUM_SLOTS  = 64;
   localparam int COUNT_BITS = 16;
   localparam int KEY_BITS   = 32;
   localparam int IDX_BITS   = $clog2(NUM_SLOTS);
   localparam int ENTRY_BITS = KEY_BITS + COUNT_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(NUM_SLOTS - 1);

   // Operation codes on req_op.
   localparam logic [1:0] OP_ACQUIRE = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_QUERY   = 2'd2;

   // Status codes on rsp_status.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Outcome of one pass over all slots.
   typedef struct packed {
      logic                  done;
      logic                  hit;
      logic [IDX_BITS-1:0]   hit_idx;
      logic [COUNT_BITS-1:0] hit_count;
      logic                  free;
      logic [IDX_BITS-1:0]   free_idx;
   } scan_result_type;

endpackage

// ===== hdl/refcounted_open_key_table.sv =====
// Top level of the reference-counted slot table: command FSM, slot RAM,
// live bits and the read-modify-write of one slot. Depends on rcokt_pkg,
// rcokt_ram and rcokt_scan.
//
// A command is taken when start is high and busy is low. Every command scans
// all NUM_SLOTS slots of the slot RAM, one read per cycle, then updates at
// most one slot. After the last slot is checked, the scanner's done flag is
// registered, the FSM moves to ST_DONE to update the slot, and rsp_strobe is
// registered from that state. A new command can be taken at the edge that
// takes the result beat, not before. The single RAM read port sets the
// length of the scan. The result is shown for one cycle only and must be
// captured then. Reset clears the live bit of every slot at once, so the
// table is usable in the cycle after reset.
module refcounted_open_key_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_op,
   input  logic [rcokt_pkg::KEY_BITS-1:0]     req_key,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_is_open
);

   rcokt_pkg::state_type               state_ff, state_in;
   logic [1:0]                         op_ff, op_in;
   logic [rcokt_pkg::KEY_BITS-1:0]     key_ff, key_in;
   logic [rcokt_pkg::NUM_SLOTS-1:0]    live_ff, live_in;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;
   logic                               rsp_is_open_ff, rsp_is_open_in;

   logic                               accept;
   logic                               rd_en;
   logic [rcokt_pkg::IDX_BITS-1:0]     rd_addr;
   logic [rcokt_pkg::ENTRY_BITS-1:0]   rd_data;
   logic                               wr_en;
   logic [rcokt_pkg::IDX_BITS-1:0]     wr_addr;
   logic [rcokt_pkg::COUNT_BITS-1:0]   wr_count;
   logic [rcokt_pkg::ENTRY_BITS-1:0]   wr_data;
   rcokt_pkg::scan_result_type         scan_res;

   assign accept = start && (state_ff == rcokt_pkg::ST_IDLE);
   assign busy   = (state_ff != rcokt_pkg::ST_IDLE);

   rcokt_ram #(
      .WIDTH (rcokt_pkg::ENTRY_BITS),
      .DEPTH (rcokt_pkg::NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rcokt_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .scan_start (accept),
      .key        (key_ff),
      .live       (live_ff),
      .rd_data    (rd_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .result     (scan_res)
   );

   assign wr_data = {key_ff, wr_count};

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      live_in        = live_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_is_open_in = rsp_is_open_ff;
      wr_en          = 1'b0;
      wr_addr        = scan_res.hit_idx;
      wr_count       = scan_res.hit_count;

      case (state_ff)
         rcokt_pkg::ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               key_in   = req_key;
               state_in = rcokt_pkg::ST_SCAN;
            end
         end
         rcokt_pkg::ST_SCAN: begin
            if (scan_res.done) begin
               state_in = rcokt_pkg::ST_DONE;
            end
         end
         rcokt_pkg::ST_DONE: begin
            rsp_strobe_in  = 1'b1;
            rsp_status_in  = rcokt_pkg::STATUS_OK;
            rsp_is_open_in = scan_res.hit;
            case (op_ff)
               rcokt_pkg::OP_ACQUIRE: begin
                  if (scan_res.hit) begin
                     if (scan_res.hit_count == rcokt_pkg::COUNT_MAX) begin
                        rsp_status_in = rcokt_pkg::STATUS_SATURATED;
                     end else begin
                        wr_en    = 1'b1;
                        wr_count = scan_res.hit_count + 1'b1;
                     end
                  end else if (scan_res.free) begin
                     wr_en                      = 1'b1;
                     wr_addr                    = scan_res.free_idx;
                     wr_count                   = rcokt_pkg::COUNT_BITS'(1);
                     live_in[scan_res.free_idx] = 1'b1;
                     rsp_is_open_in             = 1'b1;
                  end else begin
                     rsp_status_in = rcokt_pkg::STATUS_FULL;
                  end
               end
               rcokt_pkg::OP_RELEASE: begin
                  if (scan_res.hit) begin
                     wr_en    = 1'b1;
                     wr_count = scan_res.hit_count - 1'b1;
                     // The last reference frees the slot.
                     if (wr_count == '0) begin
                        live_in[scan_res.hit_idx] = 1'b0;
                        rsp_is_open_in            = 1'b0;
                     end
                  end else begin
                     rsp_status_in = rcokt_pkg::STATUS_NOT_FOUND;
                  end
               end
               default: begin
                  // Query and the unused code only report liveness.
               end
            endcase
            state_in = rcokt_pkg::ST_IDLE;
         end
         default: begin
            state_in = rcokt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rcokt_pkg::ST_IDLE;
         live_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff          <= op_in;
      key_ff         <= key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_is_open_ff <= rsp_is_open_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_is_open = rsp_is_open_ff;

   // The scan may only finish while a command waits for it.
   a_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_res.done |-> (state_ff == rcokt_pkg::ST_SCAN))
      else $error("scan finished outside of a command");

   // The slot RAM is written only in the update cycle.
   a_write_in_done: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == rcokt_pkg::ST_DONE))
      else $error("slot RAM written outside of the update cycle");

   // Every result beat follows an update cycle.
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == rcokt_pkg::ST_DONE))
      else $error("result beat without an update cycle");

   // A full report means every slot really is live.
   a_full_all_live: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_status_ff == rcokt_pkg::STATUS_FULL)) |-> (&live_ff))
      else $error("table full reported with a free slot");

endmodule

// ===== hdl/rcokt_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package dependency.
module rcokt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rcokt_scan.sv =====
// Slot scanner: walks the slot RAM one address per cycle and tracks the live
// slot holding the key and the lowest free slot. Depends on rcokt_pkg.
module rcokt_scan (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 scan_start,
   input  logic [rcokt_pkg::KEY_BITS-1:0]       key,
   input  logic [rcokt_pkg::NUM_SLOTS-1:0]      live,
   input  logic [rcokt_pkg::ENTRY_BITS-1:0]     rd_data,
   output logic                                 rd_en,
   output logic [rcokt_pkg::IDX_BITS-1:0]       rd_addr,
   output rcokt_pkg::scan_result_type           result
);

   logic                               issuing_ff, issuing_in;
   logic [rcokt_pkg::IDX_BITS-1:0]     addr_ff, addr_in;
   logic                               chk_ff, chk_in;
   logic [rcokt_pkg::IDX_BITS-1:0]     chk_idx_ff, chk_idx_in;
   logic                               done_ff, done_in;
   logic                               hit_ff, hit_in;
   logic [rcokt_pkg::IDX_BITS-1:0]     hit_idx_ff, hit_idx_in;
   logic [rcokt_pkg::COUNT_BITS-1:0]   hit_count_ff, hit_count_in;
   logic                               free_ff, free_in;
   logic [rcokt_pkg::IDX_BITS-1:0]     free_idx_ff, free_idx_in;
   logic [rcokt_pkg::KEY_BITS-1:0]     entry_key;
   logic [rcokt_pkg::COUNT_BITS-1:0]   entry_count;

   assign entry_key   = rd_data[rcokt_pkg::ENTRY_BITS-1:rcokt_pkg::COUNT_BITS];
   assign entry_count = rd_data[rcokt_pkg::COUNT_BITS-1:0];

   always_comb begin
      issuing_in   = issuing_ff;
      addr_in      = addr_ff;
      chk_in       = 1'b0;
      chk_idx_in   = addr_ff;
      done_in      = 1'b0;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_count_in = hit_count_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;

      if (scan_start) begin
         issuing_in = 1'b1;
         addr_in    = '0;
         hit_in     = 1'b0;
         free_in    = 1'b0;
      end else if (issuing_ff) begin
         chk_in  = 1'b1;
         addr_in = addr_ff + 1'b1;
         if (addr_ff == rcokt_pkg::LAST_IDX) begin
            issuing_in = 1'b0;
         end
      end

      // Read data for chk_idx_ff arrives in the cycle after its address is issued.
      if (chk_ff) begin
         if (live[chk_idx_ff]) begin
            if (entry_key == key) begin
               hit_in       = 1'b1;
               hit_idx_in   = chk_idx_ff;
               hit_count_in = entry_count;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
         done_in = (chk_idx_ff == rcokt_pkg::LAST_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         chk_ff     <= 1'b0;
         done_ff    <= 1'b0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
      end else begin
         issuing_ff <= issuing_in;
         chk_ff     <= chk_in;
         done_ff    <= done_in;
         hit_ff     <= hit_in;
         free_ff    <= free_in;
      end
      addr_ff      <= addr_in;
      chk_idx_ff   <= chk_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_count_ff <= hit_count_in;
      free_idx_ff  <= free_idx_in;
   end

   assign rd_en   = issuing_ff;
   assign rd_addr = addr_ff;

   assign result.done      = done_ff;
   assign result.hit       = hit_ff;
   assign result.hit_idx   = hit_idx_ff;
   assign result.hit_count = hit_count_ff;
   assign result.free      = free_ff;
   assign result.free_idx  = free_idx_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for refcounted_open_key_table: directed, table-full, random and deep-count tests.
// Depends on rcokt_pkg and the refcounted_open_key_table RTL only.
module tb_top;

   localparam logic [1:0] OP_UNUSED = 2'd3;  // decoded by the block as a query
   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic [1:0]                       op;
      logic [rcokt_pkg::KEY_BITS-1:0]   key;
      logic [1:0]                       status;
      logic                             is_open;
   } slot_answer_type;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [1:0]                        req_op;
   logic [rcokt_pkg::KEY_BITS-1:0]    req_key;
   logic                              rsp_strobe;
   logic [1:0]                        rsp_status;
   logic                              rsp_is_open;

   // Shadow copy of the slot table, updated as each command beat is taken.
   logic [rcokt_pkg::KEY_BITS-1:0]    shadow_key   [rcokt_pkg::NUM_SLOTS];
   logic [rcokt_pkg::COUNT_BITS-1:0]  shadow_count [rcokt_pkg::NUM_SLOTS];
   slot_answer_type                   answers_due  [$];
   logic [rcokt_pkg::KEY_BITS-1:0]    key_pool     [128];
   int                                mismatch_count;
   bit                                no_idle;

   refcounted_open_key_table dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_op      (req_op),
      .req_key     (req_key),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_is_open (rsp_is_open)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #250_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      // Keep the log short when something goes badly wrong.
      if (mismatch_count <= PRINT_CAP) begin
         $display("%0t ns: error: %s", $time, what);
      end
   endtask

   // Applies one command to the shadow table and returns the answer it must give.
   function automatic slot_answer_type apply_to_shadow(
      input logic [1:0] op, input logic [rcokt_pkg::KEY_BITS-1:0] key);
      slot_answer_type ans;
      int              hit;
      int              free_slot;
      int              i;
      hit       = -1;
      free_slot = -1;
      for (i = rcokt_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (shadow_count[i] != '0 && shadow_key[i] == key) hit = i;
         if (shadow_count[i] == '0) free_slot = i;
      end
      ans.op      = op;
      ans.key     = key;
      ans.status  = rcokt_pkg::STATUS_OK;
      ans.is_open = 1'b0;
      if (op == rcokt_pkg::OP_ACQUIRE) begin
         if (hit >= 0) begin
            if (shadow_count[hit] == rcokt_pkg::COUNT_MAX) begin
               ans.status = rcokt_pkg::STATUS_SATURATED;
            end else begin
               shadow_count[hit] = shadow_count[hit] + 1'b1;
            end
            ans.is_open = 1'b1;
         end else if (free_slot < 0) begin
            ans.status = rcokt_pkg::STATUS_FULL;
         end else begin
            shadow_key[free_slot]   = key;
            shadow_count[free_slot] = rcokt_pkg::COUNT_BITS'(1);
            ans.is_open             = 1'b1;
         end
      end else if (op == rcokt_pkg::OP_RELEASE) begin
         if (hit >= 0) begin
            shadow_count[hit] = shadow_count[hit] - 1'b1;
            ans.is_open       = (shadow_count[hit] != '0);
         end else begin
            ans.status = rcokt_pkg::STATUS_NOT_FOUND;
         end
      end else begin
         ans.is_open = (hit >= 0);
      end
      return ans;
   endfunction

   // Mostly back-to-back, some short pauses, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 80) return $urandom_range(1, 4);
      if (r < 95) return $urandom_range(55, 80);
      return $urandom_range(100, 200);
   endfunction

   // Sends one command beat; start stays high afterwards unless a gap follows.
   task automatic send_cmd(input logic [1:0] op,
                           input logic [rcokt_pkg::KEY_BITS-1:0] key,
                           input int gap);
      start   <= 1'b1;
      req_op  <= op;
      req_key <= key;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      answers_due.push_back(apply_to_shadow(op, key));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      slot_answer_type due;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing outstanding: status %0d open %b",
                                      rsp_status, rsp_is_open));
         end else begin
            due = answers_due.pop_front();
            if (rsp_status !== due.status) begin
               report_mismatch($sformatf("op %0d key %h: status %0d, want %0d",
                                         due.op, due.key, rsp_status, due.status));
            end
            if (rsp_is_open !== due.is_open) begin
               report_mismatch($sformatf("op %0d key %h: is_open %b, want %b",
                                         due.op, due.key, rsp_is_open, due.is_open));
            end
         end
      end
   end

   task automatic test_directed();
      send_cmd(rcokt_pkg::OP_QUERY,   32'h0000_0000, pick_gap());
      send_cmd(rcokt_pkg::OP_RELEASE, 32'hFFFF_FFFF, pick_gap());
      send_cmd(rcokt_pkg::OP_ACQUIRE, 32'h0000_0000, pick_gap());
      send_cmd(rcokt_pkg::OP_ACQUIRE, 32'hFFFF_FFFF, pick_gap());
      send_cmd(rcokt_pkg::OP_ACQUIRE, 32'h0000_0000, pick_gap());
      send_cmd(rcokt_pkg::OP_QUERY,   32'h0000_0000, pick_gap());
      send_cmd(OP_UNUSED,             32'hFFFF_FFFF, pick_gap());
      send_cmd(rcokt_pkg::OP_QUERY,   32'h0000_0001, pick_gap());
      send_cmd(rcokt_pkg::OP_QUERY,   32'h7FFF_FFFF, pick_gap());
      send_cmd(OP_UNUSED,             32'h8000_0000, pick_gap());
      // Two references on key zero: the second release frees the slot.
      send_cmd(rcokt_pkg::OP_RELEASE, 32'h0000_0000, pick_gap());
      send_cmd(rcokt_pkg::OP_RELEASE, 32'h0000_0000, pick_gap());
      send_cmd(rcokt_pkg::OP_RELEASE, 32'h0000_0000, pick_gap());
      send_cmd(rcokt_pkg::OP_QUERY,   32'h0000_0000, pick_gap());
      // The freed lowest slot is reused while a higher slot stays live.
      send_cmd(rcokt_pkg::OP_ACQUIRE, 32'h8000_0000, pick_gap());
      send_cmd(rcokt_pkg::OP_QUERY,   32'h8000_0000, pick_gap());
      send_cmd(rcokt_pkg::OP_RELEASE, 32'hFFFF_FFFE, pick_gap());
      send_cmd(rcokt_pkg::OP_RELEASE, 32'hFFFF_FFFF, pick_gap());
      send_cmd(rcokt_pkg::OP_QUERY,   32'hFFFF_FFFF, pick_gap());
      send_cmd(rcokt_pkg::OP_RELEASE, 32'h8000_0000, pick_gap());
      send_cmd(rcokt_pkg::OP_QUERY,   32'h8000_0000, pick_gap());
   endtask

   task automatic test_table_full();
      logic [rcokt_pkg::KEY_BITS-1:0] salt;
      logic [rcokt_pkg::KEY_BITS-1:0] fill_key [rcokt_pkg::NUM_SLOTS + 2];
      int                             i;
      salt = $urandom;
      // Bits 7 to 13 carry the index, so every key is distinct.
      for (i = 0; i < rcokt_pkg::NUM_SLOTS + 2; i++) begin
         fill_key[i] = {salt[31:14], 7'(i), salt[6:0]};
      end
      for (i = 0; i < rcokt_pkg::NUM_SLOTS; i++) begin
         send_cmd(rcokt_pkg::OP_ACQUIRE, fill_key[i], pick_gap());
      end
      send_cmd(rcokt_pkg::OP_ACQUIRE, fill_key[rcokt_pkg::NUM_SLOTS], pick_gap());
      send_cmd(rcokt_pkg::OP_QUERY,   fill_key[rcokt_pkg::NUM_SLOTS], pick_gap());
      send_cmd(rcokt_pkg::OP_ACQUIRE, fill_key[5], pick_gap());
      send_cmd(rcokt_pkg::OP_RELEASE, fill_key[17], pick_gap());
      send_cmd(rcokt_pkg::OP_ACQUIRE, fill_key[rcokt_pkg::NUM_SLOTS], pick_gap());
      send_cmd(rcokt_pkg::OP_ACQUIRE, fill_key[rcokt_pkg::NUM_SLOTS + 1], pick_gap());
      send_cmd(rcokt_pkg::OP_QUERY,   fill_key[rcokt_pkg::NUM_SLOTS - 1], pick_gap());
      for (i = 0; i < rcokt_pkg::NUM_SLOTS + 2; i++) begin
         send_cmd(rcokt_pkg::OP_RELEASE, fill_key[i], pick_gap());
      end
      send_cmd(rcokt_pkg::OP_RELEASE, fill_key[5], pick_gap());
      send_cmd(rcokt_pkg::OP_QUERY,   fill_key[5], pick_gap());
   endtask

   // One random phase: keys mostly from the first pool_size pool entries.
   task automatic run_random_phase(input int n_items, input int pool_size,
                                   input int acq_pct, input int rel_pct);
      logic [1:0]                     op;
      logic [rcokt_pkg::KEY_BITS-1:0] key;
      int                             r;
      int                             n;
      for (n = 0; n < n_items; n++) begin
         if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < acq_pct) op = rcokt_pkg::OP_ACQUIRE;
         else if (r < acq_pct + rel_pct) op = rcokt_pkg::OP_RELEASE;
         else if (r < 97) op = rcokt_pkg::OP_QUERY;
         else op = OP_UNUSED;
         if ($urandom_range(0, 9) == 0) key = $urandom;
         else key = key_pool[$urandom_range(0, pool_size - 1)];
         send_cmd(op, key, pick_gap());
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random();
      logic [rcokt_pkg::KEY_BITS-1:0] base;
      int                             i;
      base        = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;
      // Neighbors of one base key that differ in a single bit catch compare faults.
      for (i = 2; i < 128; i++) begin
         if (i < 34) key_pool[i] = base ^ (32'h1 << (i - 2));
         else key_pool[i] = $urandom;
      end
      key_pool[2 + $urandom_range(0, 31)] = base;
      run_random_phase(320, 12, 40, 40);
      run_random_phase(250, 100, 75, 10);
      run_random_phase(300, 100, 10, 80);
   endtask

   // Stacks many references on one key and takes them all off again.
   task automatic test_deep_count();
      logic [rcokt_pkg::KEY_BITS-1:0] key;
      int                             n;
      key = $urandom;
      for (n = 0; n < 24; n++) send_cmd(rcokt_pkg::OP_ACQUIRE, key, pick_gap());
      send_cmd(rcokt_pkg::OP_QUERY, key, pick_gap());
      send_cmd(rcokt_pkg::OP_QUERY, ~key, pick_gap());
      for (n = 0; n < 24; n++) send_cmd(rcokt_pkg::OP_RELEASE, key, pick_gap());
      send_cmd(rcokt_pkg::OP_RELEASE, key, pick_gap());
      send_cmd(rcokt_pkg::OP_QUERY,   key, pick_gap());
      send_cmd(rcokt_pkg::OP_ACQUIRE, ~key, pick_gap());
   endtask

   initial begin
      int i;
      mismatch_count = 0;
      no_idle        = 1'b0;
      for (i = 0; i < rcokt_pkg::NUM_SLOTS; i++) begin
         shadow_key[i]   = '0;
         shadow_count[i] = '0;
      end
      reset   <= 1'b1;
      start   <= 1'b0;
      req_op  <= rcokt_pkg::OP_QUERY;
      req_key <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_table_full();
      test_random();
      test_deep_count();

      start <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (rcokt_pkg::NUM_SLOTS + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rcokt_pkg.sv
hdl/rcokt_ram.sv
hdl/rcokt_scan.sv
hdl/refcounted_open_key_table.sv
tb/tb_top.sv
